// File: rtl/core/cfrp_pkg.sv
// cfrp_pkg: types and constants for the cube face ray projection block
// no dependencies

package cfrp_pkg;

  localparam int COEF_W = 16;
  localparam int RAY_W  = 16;
  localparam int ROW_W  = 3 * COEF_W;
  localparam int PROD_W = 2 * COEF_W;
  localparam int CAM_W  = PROD_W + 1;
  localparam int FOC_W  = 16;
  localparam int DIM_W  = 13;
  localparam int PIX_W  = 12;
  localparam int ST_W   = 2;
  localparam int FA_W   = FOC_W + 1 + CAM_W;
  localparam int DZ_W   = DIM_W + 1 + CAM_W;
  localparam int NUM_W  = 52;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 48;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_X   = 3'd0,
    REG_ROT_Y   = 3'd1,
    REG_ROT_Z   = 3'd2,
    REG_FOCAL_H = 3'd3,
    REG_FOCAL_V = 3'd4,
    REG_FACE_W  = 3'd5,
    REG_FACE_H  = 3'd6
  } cfg_reg_t;

  localparam logic [ST_W-1:0] ST_VALID  = 2'd0;
  localparam logic [ST_W-1:0] ST_BEHIND = 2'd1;
  localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;
  localparam logic [ST_W-1:0] ST_UNUSED = 2'd3;

  localparam logic [ROW_W-1:0] ROT_X_RST = 48'd16384;
  localparam logic [ROW_W-1:0] ROT_Y_RST = 48'd1073741824;
  localparam logic [ROW_W-1:0] ROT_Z_RST = 48'd70368744177664;
  localparam logic [FOC_W-1:0] FOCAL_RST = 16'd4096;
  localparam logic [DIM_W-1:0] DIM_RST   = 13'd512;

  typedef struct packed {
    logic signed [RAY_W-1:0] ray_x;
    logic signed [RAY_W-1:0] ray_y;
    logic signed [RAY_W-1:0] ray_z;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_col;
    logic [PIX_W-1:0] pixel_row;
    logic [ST_W-1:0]  status;
  } out_item_t;

endpackage

// File: rtl/core/cfrp_div.sv
// cfrp_div: pipelined restoring divider, one quotient bit per stage
// depends on cfrp_pkg for the dividend width

module cfrp_div #(
  parameter int QW = 12
) (
  input  logic                          clk,
  input  logic [cfrp_pkg::NUM_W-1:0]    dividend,
  input  logic [cfrp_pkg::NUM_W-1:0]    divisor,
  output logic [QW-1:0]                 quotient
);

  logic [cfrp_pkg::NUM_W-1:0] rem_r [1:QW];
  logic [cfrp_pkg::NUM_W-1:0] den_r [1:QW];
  logic [QW-1:0]              quo_r [1:QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [cfrp_pkg::NUM_W-1:0] rem_w;
    logic [cfrp_pkg::NUM_W-1:0] den_w;
    logic [QW-1:0]              quo_w;
    logic [cfrp_pkg::NUM_W-1:0] sub_w;
    logic                       take_w;
    if (k == 0) begin : g_head
      assign rem_w = dividend;
      assign den_w = divisor;
      assign quo_w = '0;
    end else begin : g_body
      assign rem_w = rem_r[k];
      assign den_w = den_r[k];
      assign quo_w = quo_r[k];
    end
    assign sub_w  = den_w << SH;
    assign take_w = (rem_w >= sub_w);
    always_ff @(posedge clk) begin
      rem_r[k+1] <= take_w ? (rem_w - sub_w) : rem_w;
      den_r[k+1] <= den_w;
      quo_r[k+1] <= quo_w | (QW'(take_w) << SH);
    end
  end

  assign quotient = quo_r[QW];

endmodule

// File: rtl/core/cube_face_ray_projection.sv
// cube_face_ray_projection: rotates a ray and projects it onto a cube face
// depends on cfrp_pkg and cfrp_div
// accepts one item per cycle
// throughput set by a fully pipelined datapath; the divider takes one bit a stage
// busy is always low and the receiver cannot stall
// synchronous reset clears valid bits and loads the register defaults

module cube_face_ray_projection #(
  parameter int MAX_FACE_DIM = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  cfrp_pkg::in_item_t                in_data,
  output logic                              out_valid,
  output cfrp_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfrp_pkg::IDX_W-1:0]        cfg_index,
  input  logic [cfrp_pkg::CFG_W-1:0]        cfg_data
);

  localparam int QW  = $clog2(MAX_FACE_DIM);
  localparam int NS  = QW + 6;
  localparam int NW  = cfrp_pkg::NUM_W;
  localparam int CW  = cfrp_pkg::CAM_W;

  logic [cfrp_pkg::ROW_W-1:0] rot_r [3];
  logic [cfrp_pkg::FOC_W-1:0] focal_r [2];
  logic [cfrp_pkg::DIM_W-1:0] dim_cfg_r [2];
  logic [cfrp_pkg::DIM_W-1:0] dim_w [2];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_r[0]     <= cfrp_pkg::ROT_X_RST;
      rot_r[1]     <= cfrp_pkg::ROT_Y_RST;
      rot_r[2]     <= cfrp_pkg::ROT_Z_RST;
      focal_r[0]   <= cfrp_pkg::FOCAL_RST;
      focal_r[1]   <= cfrp_pkg::FOCAL_RST;
      dim_cfg_r[0] <= cfrp_pkg::DIM_RST;
      dim_cfg_r[1] <= cfrp_pkg::DIM_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfrp_pkg::REG_ROT_X:   rot_r[0]     <= cfg_data;
        cfrp_pkg::REG_ROT_Y:   rot_r[1]     <= cfg_data;
        cfrp_pkg::REG_ROT_Z:   rot_r[2]     <= cfg_data;
        cfrp_pkg::REG_FOCAL_H: focal_r[0]   <= cfg_data[cfrp_pkg::FOC_W-1:0];
        cfrp_pkg::REG_FOCAL_V: focal_r[1]   <= cfg_data[cfrp_pkg::FOC_W-1:0];
        cfrp_pkg::REG_FACE_W:  dim_cfg_r[0] <= cfg_data[cfrp_pkg::DIM_W-1:0];
        cfrp_pkg::REG_FACE_H:  dim_cfg_r[1] <= cfg_data[cfrp_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dim_w[a] = (32'(dim_cfg_r[a]) > MAX_FACE_DIM) ?
                 cfrp_pkg::DIM_W'(MAX_FACE_DIM) : dim_cfg_r[a];
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // valid line
  logic [NS:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NS-1:0], start & ~busy};
    end
  end

  // stage 1: input register
  logic signed [cfrp_pkg::RAY_W-1:0] ray_r [3];
  always_ff @(posedge clk) begin
    ray_r[0] <= in_data.ray_x;
    ray_r[1] <= in_data.ray_y;
    ray_r[2] <= in_data.ray_z;
  end

  // stage 2: coefficient products
  logic signed [cfrp_pkg::PROD_W-1:0] prod_r [3][3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        prod_r[r][k] <= $signed(rot_r[r][16*k +: cfrp_pkg::COEF_W]) * ray_r[k];
      end
    end
  end

  // stage 3: camera coordinates
  logic signed [CW-1:0] cam_r [3];
  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      cam_r[r] <= CW'(prod_r[r][0]) + CW'(prod_r[r][1]) + CW'(prod_r[r][2]);
    end
  end

  // stage 4: focal and dimension products
  logic signed [cfrp_pkg::FA_W-1:0] fa_r [2];
  logic signed [cfrp_pkg::DZ_W-1:0] dz_r [2];
  logic signed [CW-1:0]             z4_r;
  logic [1:0]                       dzero4_r;
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      fa_r[a]     <= $signed({1'b0, focal_r[a]}) * cam_r[a];
      dz_r[a]     <= $signed({1'b0, dim_w[a]}) * cam_r[2];
      dzero4_r[a] <= (dim_w[a] == '0);
    end
    z4_r <= cam_r[2];
  end

  // stage 5: numerators and bounds
  logic signed [NW-1:0] num_r [2];
  logic signed [NW-1:0] bnd_r [2];
  logic signed [NW-1:0] lo5_r;
  logic signed [CW-1:0] z5_r;
  logic [1:0]           dzero5_r;
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      num_r[a] <= (NW'(fa_r[a]) <<< 1) + (NW'(dz_r[a]) <<< 4);
      bnd_r[a] <= NW'(dz_r[a]) <<< 5;
    end
    lo5_r    <= NW'(z4_r) <<< 5;
    z5_r     <= z4_r;
    dzero5_r <= dzero4_r;
  end

  // stage 6: status and divider operands
  logic [cfrp_pkg::ST_W-1:0] st6_w;
  logic [1:0]                outside_w;
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      outside_w[a] = dzero5_r[a] || (num_r[a] + lo5_r <= 0) || (num_r[a] >= bnd_r[a]);
    end
    if (z5_r <= 0) begin
      st6_w = cfrp_pkg::ST_BEHIND;
    end else if (|outside_w) begin
      st6_w = cfrp_pkg::ST_OUTSIDE;
    end else begin
      st6_w = cfrp_pkg::ST_VALID;
    end
  end

  logic [NW-1:0]             dvd_r [2];
  logic [NW-1:0]             dvs_r;
  logic [cfrp_pkg::ST_W-1:0] st_r [QW+1];
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      dvd_r[a] <= num_r[a][NW-1] ? '0 : NW'(unsigned'(num_r[a]));
    end
    dvs_r    <= NW'(unsigned'(lo5_r));
    st_r[0]  <= st6_w;
    for (int s = 0; s < QW; s++) begin
      st_r[s+1] <= st_r[s];
    end
  end

  logic [QW-1:0] quo_w [2];
  for (genvar a = 0; a < 2; a++) begin : g_axis
    cfrp_div #(.QW(QW)) u_div (
      .clk      (clk),
      .dividend (dvd_r[a]),
      .divisor  (dvs_r),
      .quotient (quo_w[a])
    );
  end

  // output register
  cfrp_pkg::out_item_t out_r;
  always_ff @(posedge clk) begin
    if (st_r[QW] == cfrp_pkg::ST_VALID) begin
      out_r.pixel_col <= cfrp_pkg::PIX_W'(quo_w[0]);
      out_r.pixel_row <= cfrp_pkg::PIX_W'(quo_w[1]);
    end else begin
      out_r.pixel_col <= '0;
      out_r.pixel_row <= '0;
    end
    out_r.status <= st_r[QW];
  end

  assign out_valid = v_r[NS];
  assign out_data  = out_r;

endmodule

// File: rtl/core/cfrp_chk.sv
// cfrp_chk: port-level checks for cube_face_ray_projection, bound to the top level
// depends on cfrp_pkg

module cfrp_chk #(
  parameter int MAX_FACE_DIM = 4096
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input cfrp_pkg::out_item_t out_data
);

  localparam int LAT = $clog2(MAX_FACE_DIM) + 7;
  localparam int CW  = $clog2(LAT + 1);

  logic [CW-1:0] settle_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= '0;
    end else if (settle_r != CW'(LAT)) begin
      settle_r <= settle_r + 1'b1;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r == CW'(LAT)) |-> (out_valid == $past(start && !busy, LAT)))
    else $error("result strobe does not follow an accepted item");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != cfrp_pkg::ST_VALID) |->
    (out_data.pixel_col == '0 && out_data.pixel_row == '0))
    else $error("nonzero pixel on a failed projection");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != cfrp_pkg::ST_UNUSED))
    else $error("unused status code");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

endmodule

bind cube_face_ray_projection cfrp_chk #(.MAX_FACE_DIM(MAX_FACE_DIM)) u_cfrp_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

// File: test/tb.sv
// tb: self-checking testbench for cube_face_ray_projection
// holds a projection scoreboard class and the top module that drives the block
// depends on cfrp_pkg and the block's rtl
`timescale 1ns / 1ps

module tb;

  localparam logic [cfrp_pkg::IDX_W-1:0] REG_NONE = 3'd7;
  localparam int DRAIN_CYC = 30;
  localparam int MAX_DIM = 4096;

  class proj_scoreboard;
    logic [cfrp_pkg::ROW_W-1:0] rot[3];
    logic [cfrp_pkg::FOC_W-1:0] foc_h, foc_v;
    logic [cfrp_pkg::DIM_W-1:0] dim_w, dim_h;
    cfrp_pkg::out_item_t pix_q[$];
    int errors, reported, n_in, n_out;
    int n_stat[4];

    function void reset_regs();
      rot[0] = cfrp_pkg::ROT_X_RST;
      rot[1] = cfrp_pkg::ROT_Y_RST;
      rot[2] = cfrp_pkg::ROT_Z_RST;
      foc_h = cfrp_pkg::FOCAL_RST;
      foc_v = cfrp_pkg::FOCAL_RST;
      dim_w = cfrp_pkg::DIM_RST;
      dim_h = cfrp_pkg::DIM_RST;
    endfunction

    function void write_reg(logic [cfrp_pkg::IDX_W-1:0] idx,
                            logic [cfrp_pkg::CFG_W-1:0] val);
      case (idx)
        cfrp_pkg::REG_ROT_X: rot[0] = val;
        cfrp_pkg::REG_ROT_Y: rot[1] = val;
        cfrp_pkg::REG_ROT_Z: rot[2] = val;
        cfrp_pkg::REG_FOCAL_H: foc_h = val[cfrp_pkg::FOC_W-1:0];
        cfrp_pkg::REG_FOCAL_V: foc_v = val[cfrp_pkg::FOC_W-1:0];
        cfrp_pkg::REG_FACE_W: dim_w = val[cfrp_pkg::DIM_W-1:0];
        cfrp_pkg::REG_FACE_H: dim_h = val[cfrp_pkg::DIM_W-1:0];
        default: ;
      endcase
    endfunction

    function longint rotate(logic [cfrp_pkg::ROW_W-1:0] r, cfrp_pkg::in_item_t it);
      longint acc;
      acc = longint'($signed(r[15:0])) * longint'(it.ray_x);
      acc += longint'($signed(r[31:16])) * longint'(it.ray_y);
      acc += longint'($signed(r[47:32])) * longint'(it.ray_z);
      return acc;
    endfunction

    function longint clamp(logic [cfrp_pkg::DIM_W-1:0] d);
      return (d > MAX_DIM) ? longint'(MAX_DIM) : longint'(d);
    endfunction

    function void note_ray(cfrp_pkg::in_item_t it);
      longint cx, cy, cz, w, h, col, row;
      cfrp_pkg::out_item_t p;
      n_in++;
      cx = rotate(rot[0], it);
      cy = rotate(rot[1], it);
      cz = rotate(rot[2], it);
      p = '0;
      if (cz <= 0) begin
        p.status = cfrp_pkg::ST_BEHIND;
      end else begin
        w = clamp(dim_w);
        h = clamp(dim_h);
        col = (2 * longint'(foc_h) * cx + 16 * w * cz) / (32 * cz);
        row = (2 * longint'(foc_v) * cy + 16 * h * cz) / (32 * cz);
        if (col < 0 || row < 0 || col >= w || row >= h) begin
          p.status = cfrp_pkg::ST_OUTSIDE;
        end else begin
          p.pixel_col = col[cfrp_pkg::PIX_W-1:0];
          p.pixel_row = row[cfrp_pkg::PIX_W-1:0];
          p.status = cfrp_pkg::ST_VALID;
        end
      end
      pix_q.push_back(p);
    endfunction

    function void check_pixel(cfrp_pkg::out_item_t got);
      cfrp_pkg::out_item_t exp_p;
      n_out++;
      if (pix_q.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result col=%0d row=%0d status=%0d",
                   got.pixel_col, got.pixel_row, got.status);
        end
        return;
      end
      exp_p = pix_q.pop_front();
      n_stat[exp_p.status]++;
      if (got.pixel_col !== exp_p.pixel_col || got.pixel_row !== exp_p.pixel_row ||
          got.status !== exp_p.status) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: exp col=%0d row=%0d status=%0d, got col=%0d row=%0d status=%0d",
                   exp_p.pixel_col, exp_p.pixel_row, exp_p.status,
                   got.pixel_col, got.pixel_row, got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  cfrp_pkg::in_item_t in_data = '0;
  logic out_valid;
  cfrp_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [cfrp_pkg::IDX_W-1:0] cfg_index = '0;
  logic [cfrp_pkg::CFG_W-1:0] cfg_data = '0;

  proj_scoreboard sb = new();
  int idle_pct;

  cube_face_ray_projection u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_ray(in_data);
      if (out_valid) sb.check_pixel(out_data);
    end
  end

  initial begin
    #5ms;
    $display("** cube_face_ray_projection: FAILED **");
    $finish;
  end

  task automatic push_ray(cfrp_pkg::in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_cfg(logic [cfrp_pkg::IDX_W-1:0] idx,
                           logic [cfrp_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic cfrp_pkg::in_item_t mk_ray(int x, int y, int z);
    cfrp_pkg::in_item_t it;
    it.ray_x = x[15:0];
    it.ray_y = y[15:0];
    it.ray_z = z[15:0];
    return it;
  endfunction

  function automatic logic [cfrp_pkg::CFG_W-1:0] pack_row(int a, int b, int c);
    return {c[15:0], b[15:0], a[15:0]};
  endfunction

  function automatic logic [cfrp_pkg::CFG_W-1:0] rand_word();
    return cfrp_pkg::CFG_W'({$urandom, $urandom});
  endfunction

  // mostly rays inside the view cone, some mirrored behind the camera, the rest fully random
  function automatic cfrp_pkg::in_item_t rand_ray();
    int z, x, y;
    if ($urandom_range(3) == 0) return mk_ray($urandom, $urandom, $urandom);
    z = $urandom_range(32767, 1);
    x = $urandom_range(2 * z) - z;
    y = $urandom_range(2 * z) - z;
    if ($urandom_range(7) == 0) z = -z;
    return mk_ray(x, y, z);
  endfunction

  task automatic set_phase(int ph);
    drain();
    case (ph % 8)
      0: begin
        write_cfg(cfrp_pkg::REG_ROT_X, pack_row(16384, 0, 0));
        write_cfg(cfrp_pkg::REG_ROT_Y, pack_row(0, 16384, 0));
        write_cfg(cfrp_pkg::REG_ROT_Z, pack_row(0, 0, 16384));
        write_cfg(cfrp_pkg::REG_FOCAL_H, cfrp_pkg::CFG_W'($urandom_range(65535)));
        write_cfg(cfrp_pkg::REG_FOCAL_V, cfrp_pkg::CFG_W'($urandom_range(65535)));
        write_cfg(cfrp_pkg::REG_FACE_W, cfrp_pkg::CFG_W'($urandom_range(4096, 1)));
        write_cfg(cfrp_pkg::REG_FACE_H, cfrp_pkg::CFG_W'($urandom_range(4096, 1)));
      end
      1: begin
        write_cfg(cfrp_pkg::REG_FOCAL_H, 48'hffff);
        write_cfg(cfrp_pkg::REG_FOCAL_V, 48'd0);
        write_cfg(cfrp_pkg::REG_FACE_W, 48'd4096);
        write_cfg(cfrp_pkg::REG_FACE_H, 48'd1);
      end
      2: begin
        write_cfg(cfrp_pkg::REG_FACE_W, 48'h1fff);
        write_cfg(cfrp_pkg::REG_FACE_H, 48'd0);
        write_cfg(REG_NONE, rand_word());
      end
      3: begin
        write_cfg(cfrp_pkg::REG_ROT_X, pack_row(-32768, -32768, -32768));
        write_cfg(cfrp_pkg::REG_ROT_Y, pack_row(32767, 32767, 32767));
        write_cfg(cfrp_pkg::REG_ROT_Z, pack_row(32767, -32768, 32767));
        write_cfg(cfrp_pkg::REG_FOCAL_H, 48'd16);
        write_cfg(cfrp_pkg::REG_FOCAL_V, 48'hffff);
        write_cfg(cfrp_pkg::REG_FACE_W, 48'd1);
        write_cfg(cfrp_pkg::REG_FACE_H, 48'd5000);
      end
      4: begin
        write_cfg(cfrp_pkg::REG_ROT_X, rand_word());
        write_cfg(cfrp_pkg::REG_ROT_Y, rand_word());
        write_cfg(cfrp_pkg::REG_ROT_Z, pack_row($urandom_range(2000), $urandom_range(2000),
                                                $urandom_range(16384, 8000)));
        write_cfg(cfrp_pkg::REG_FOCAL_H, cfrp_pkg::CFG_W'($urandom_range(8000)));
        write_cfg(cfrp_pkg::REG_FOCAL_V, cfrp_pkg::CFG_W'($urandom_range(8000)));
        write_cfg(cfrp_pkg::REG_FACE_W, cfrp_pkg::CFG_W'($urandom_range(8191)));
        write_cfg(cfrp_pkg::REG_FACE_H, cfrp_pkg::CFG_W'($urandom_range(8191)));
      end
      default: begin
        write_cfg(cfrp_pkg::REG_ROT_X,
                  pack_row($urandom_range(32767) - 16384, $urandom_range(8191), 0));
        write_cfg(cfrp_pkg::REG_ROT_Y,
                  pack_row($urandom_range(8191), $urandom_range(32767) - 16384, 0));
        write_cfg(cfrp_pkg::REG_ROT_Z, pack_row(0, 0, $urandom_range(32767, 1)));
        write_cfg(cfrp_pkg::REG_FOCAL_H, cfrp_pkg::CFG_W'($urandom_range(6000, 1000)));
        write_cfg(cfrp_pkg::REG_FOCAL_V, cfrp_pkg::CFG_W'($urandom_range(6000, 1000)));
        write_cfg(cfrp_pkg::REG_FACE_W, cfrp_pkg::CFG_W'($urandom_range(1024, 16)));
        write_cfg(cfrp_pkg::REG_FACE_H, cfrp_pkg::CFG_W'($urandom_range(1024, 16)));
      end
    endcase
  endtask

  initial begin
    int n;
    sb.reset_regs();
    idle_pct = 8;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // defaults: identity rotation, f = 256, 512 x 512
    push_ray(mk_ray(0, 0, 16384));
    push_ray(mk_ray(0, 0, 0));
    push_ray(mk_ray(0, 0, -1));
    push_ray(mk_ray(0, 0, -32768));
    push_ray(mk_ray(-16385, 0, 16384));
    push_ray(mk_ray(0, -16385, 16384));
    push_ray(mk_ray(-16384, -16384, 16384));
    push_ray(mk_ray(16383, 16383, 16384));
    push_ray(mk_ray(16384, 0, 16384));
    push_ray(mk_ray(0, 16384, 16384));
    push_ray(mk_ray(-32768, 32767, 1));
    push_ray(mk_ray(32767, -32768, 32767));
    push_ray(mk_ray(-32768, -32768, -32768));
    push_ray(mk_ray(32767, 32767, 32767));
    push_ray(mk_ray(1, -1, 1));
    push_ray(mk_ray(-1, 1, 2));

    n = 0;
    for (int ph = 0; ph < 9; ph++) begin
      set_phase(ph);
      for (int i = 0; i < 205; i++) begin
        idle_pct = (n < 615) ? 8 : (n < 1230) ? 59 : 0;
        if (i == 100 && ph == 5) drain();
        push_ray(rand_ray());
        n++;
      end
    end

    drain();
    $display("%0d rays over 9 register settings: %0d valid, %0d behind, %0d outside",
             sb.n_in, sb.n_stat[cfrp_pkg::ST_VALID], sb.n_stat[cfrp_pkg::ST_BEHIND],
             sb.n_stat[cfrp_pkg::ST_OUTSIDE]);
    $display("%0d results checked, %0d mismatches", sb.n_out, sb.errors);
    if (sb.errors == 0 && sb.pix_q.size() == 0) begin
      $display("** cube_face_ray_projection: PASSED **");
    end else begin
      $display("** cube_face_ray_projection: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cfrp_pkg.sv
rtl/core/cfrp_div.sv
rtl/core/cube_face_ray_projection.sv
rtl/core/cfrp_chk.sv
test/tb.sv
